@@ hdl/awalk_pkg.sv @@
// ----------------------------------------------------------------------------
// awalk_pkg
// Shared types and constants of the archive header walker: signature bytes,
// header type codes, status codes and the result record.
// ----------------------------------------------------------------------------
package awalk_pkg;

  localparam int unsigned SIG_LEN = 7;

  localparam logic [7:0] TYPE_MAIN = 8'h73;
  localparam logic [7:0] TYPE_FILE = 8'h74;

  localparam logic [15:0] MAIN_FIXED = 16'd7;
  localparam logic [15:0] FILE_FIXED = 16'd11;

  localparam logic [1:0] ST_END     = 2'd0;
  localparam logic [1:0] ST_OTHER   = 2'd1;
  localparam logic [1:0] ST_BAD_SIG = 2'd2;
  localparam logic [1:0] ST_TRUNC   = 2'd3;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] file_count;
  } result_t;

  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h52;
      3'd1:    b = 8'h61;
      3'd2:    b = 8'h72;
      3'd3:    b = 8'h21;
      3'd4:    b = 8'h1A;
      3'd5:    b = 8'h07;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ hdl/archive_header_walker.sv @@
// ----------------------------------------------------------------------------
// archive_header_walker
// Walks the block headers of an archive stream and reports the file count
// and an end status on the last byte.
// ----------------------------------------------------------------------------
// The block takes one archive byte per beat and can take a beat in every
// cycle but for the stall below: each byte is held in an input register,
// then the walk state is updated in one step. On the beat marked tlast a
// result beat (file count and status) is loaded into the master side output
// register, and the walk starts over with the next byte; that register may
// wait for tready while the next archive is already flowing in, stalling
// input only when a second last byte comes before the first result is taken.
module archive_header_walker #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [15:0] file_count, [17:16] status
);

  localparam int CNT_W = (COUNT_BITS < 16) ? COUNT_BITS : 16;

  logic               in_vld;
  logic [7:0]         in_byte;
  logic               in_last;
  logic               advance;
  awalk_pkg::result_t result;
  awalk_pkg::result_t out_res;
  logic               out_vld;

  assign advance       = in_vld && (!in_last || !out_vld || m_axis_tready);
  assign s_axis_tready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  awalk_core #(
    .CNT_W(CNT_W)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (in_byte),
    .is_last   (in_last),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance && in_last) begin
      out_vld <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      out_res <= result;
    end
  end

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {6'd0, out_res.status, out_res.file_count};

endmodule

@@ hdl/awalk_core.sv @@
// ----------------------------------------------------------------------------
// awalk_core
// Per-byte walk state: signature check, block header fields, skip counter
// and file counter. Gives the result for the byte presented on step.
// ----------------------------------------------------------------------------
module awalk_core #(
  parameter int CNT_W = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          data_byte,
  input  logic                is_last,
  output awalk_pkg::result_t  result
);

  localparam logic [1:0] PH_SIG  = 2'd0;
  localparam logic [1:0] PH_HDR  = 2'd1;
  localparam logic [1:0] PH_SKIP = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  logic [1:0]       phase, phase_next;
  logic [3:0]       byte_position, byte_position_next;
  logic [7:0]       block_type, block_type_next;
  logic [15:0]      block_size, block_size_next;
  logic [31:0]      packed_size, packed_size_next;
  logic [32:0]      skip_remaining, skip_remaining_next;
  logic [CNT_W-1:0] files_seen, files_seen_next;
  logic [1:0]       final_status, final_status_next;

  logic [15:0] size_full;
  logic [31:0] packed_full;
  logic [32:0] main_skip;
  logic [32:0] file_skip;
  logic [32:0] skip_dec;
  logic [1:0]  status_now;

  assign size_full   = {data_byte, block_size[7:0]};
  assign packed_full = {data_byte, packed_size[23:0]};
  assign main_skip   = {17'd0, size_full} - {17'd0, awalk_pkg::MAIN_FIXED};
  assign file_skip   = {1'b0, packed_full} + {17'd0, block_size}
                       - {17'd0, awalk_pkg::FILE_FIXED};
  assign skip_dec    = skip_remaining - 33'd1;

  always_comb begin
    phase_next          = phase;
    byte_position_next  = byte_position;
    block_type_next     = block_type;
    block_size_next     = block_size;
    packed_size_next    = packed_size;
    skip_remaining_next = skip_remaining;
    files_seen_next     = files_seen;
    final_status_next   = final_status;
    case (phase)
      PH_SIG: begin
        if (data_byte != awalk_pkg::sig_byte(byte_position[2:0])) begin
          final_status_next = awalk_pkg::ST_BAD_SIG;
          phase_next        = PH_DONE;
        end else if (byte_position >= 4'(awalk_pkg::SIG_LEN - 1)) begin
          byte_position_next = 4'd0;
          phase_next         = PH_HDR;
        end else begin
          byte_position_next = byte_position + 4'd1;
        end
      end
      PH_HDR: begin
        byte_position_next = byte_position + 4'd1;
        case (byte_position)
          4'd2: begin
            block_type_next = data_byte;
            if (data_byte != awalk_pkg::TYPE_MAIN && data_byte != awalk_pkg::TYPE_FILE) begin
              final_status_next = awalk_pkg::ST_OTHER;
              phase_next        = PH_DONE;
            end
          end
          4'd5: block_size_next = {8'd0, data_byte};
          4'd6: begin
            block_size_next  = size_full;
            packed_size_next = 32'd0;
            if (block_type == awalk_pkg::TYPE_MAIN) begin
              if (size_full < awalk_pkg::MAIN_FIXED) begin
                final_status_next = awalk_pkg::ST_TRUNC;
                phase_next        = PH_DONE;
              end else begin
                skip_remaining_next = main_skip;
                byte_position_next  = 4'd0;
                phase_next          = (main_skip == 33'd0) ? PH_HDR : PH_SKIP;
              end
            end
          end
          4'd7: packed_size_next = {24'd0, data_byte};
          4'd8: packed_size_next = {16'd0, data_byte, packed_size[7:0]};
          4'd9: packed_size_next = {8'd0, data_byte, packed_size[15:0]};
          4'd10: begin
            packed_size_next = packed_full;
            if (block_size < awalk_pkg::FILE_FIXED) begin
              final_status_next = awalk_pkg::ST_TRUNC;
              phase_next        = PH_DONE;
            end else begin
              if (files_seen != '1) begin
                files_seen_next = files_seen + CNT_W'(1);
              end
              skip_remaining_next = file_skip;
              byte_position_next  = 4'd0;
              phase_next          = (file_skip == 33'd0) ? PH_HDR : PH_SKIP;
            end
          end
          default: ;
        endcase
      end
      PH_SKIP: begin
        if (skip_remaining != 33'd0) begin
          skip_remaining_next = skip_dec;
        end
        if (skip_remaining <= 33'd1) begin
          byte_position_next = 4'd0;
          phase_next         = PH_HDR;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    case (phase_next)
      PH_DONE: status_now = final_status_next;
      PH_SIG:  status_now = awalk_pkg::ST_TRUNC;
      PH_HDR:  status_now = (byte_position_next == 4'd0) ? awalk_pkg::ST_END
                                                         : awalk_pkg::ST_TRUNC;
      default: status_now = awalk_pkg::ST_END;
    endcase
    result.status     = status_now;
    result.file_count = 16'(files_seen_next);
  end

  always_ff @(posedge clk) begin
    if (rst || (step && is_last)) begin
      phase          <= PH_SIG;
      byte_position  <= 4'd0;
      block_type     <= 8'd0;
      block_size     <= 16'd0;
      packed_size    <= 32'd0;
      skip_remaining <= 33'd0;
      files_seen     <= '0;
      final_status   <= awalk_pkg::ST_END;
    end else if (step) begin
      phase          <= phase_next;
      byte_position  <= byte_position_next;
      block_type     <= block_type_next;
      block_size     <= block_size_next;
      packed_size    <= packed_size_next;
      skip_remaining <= skip_remaining_next;
      files_seen     <= files_seen_next;
      final_status   <= final_status_next;
    end
  end

endmodule
